// ----- hw/rtl/nsr_pkg.sv -----
// nsr_pkg: widths, status codes and register defaults for the Newton square root block.
// Used by nsr_div, newton_square_root_top and nsr_checker; depends on nothing.

package nsr_pkg;

   // Fixed-point format of operand and root
   localparam int FRACTION_BITS = 16;
   localparam int VALUE_W       = 32;
   localparam int ROOT_W        = 24;
   localparam int STATUS_W      = 2;

   // Scaled operand (positive value << FRACTION_BITS) and guess width
   localparam int G_W           = VALUE_W - 1 + FRACTION_BITS;
   // Squaring operand width; a larger guess counts as a miss
   localparam int MUL_W         = 32;
   localparam int SQ_W          = 2 * MUL_W;
   localparam int DIV_CNT_W     = $clog2(G_W);

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W    = ((VALUE_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = ROOT_W + STATUS_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration registers
   localparam int TOL_W         = 32;
   localparam int LIMIT_W       = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITER_LIMIT = 1'd1;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 32'd4295;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd64;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NEG   = 2'd2;

   localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

endpackage

// ----- hw/rtl/nsr_div.sv -----
// nsr_div: restoring serial divider, one quotient bit per cycle.
// Depends on nsr_pkg for the operand width.

module nsr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nsr_pkg::G_W-1:0]   dividend,
   input  logic [nsr_pkg::G_W-1:0]   divisor,
   output logic                      done,
   output logic [nsr_pkg::G_W-1:0]   quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [nsr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [nsr_pkg::G_W-1:0]       quo_ff;
   logic [nsr_pkg::G_W-1:0]       rem_ff;
   logic [nsr_pkg::G_W-1:0]       dsr_ff;

   logic [nsr_pkg::G_W:0]         rem_shift;
   logic [nsr_pkg::G_W:0]         rem_diff;
   logic                          q_bit;
   logic [nsr_pkg::G_W-1:0]       rem_in;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[nsr_pkg::G_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      q_bit     = (rem_shift >= {1'b0, dsr_ff});
      rem_in    = q_bit ? rem_diff[nsr_pkg::G_W-1:0] : rem_shift[nsr_pkg::G_W-1:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: dividend register doubles as quotient register
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         cnt_ff <= nsr_pkg::DIV_CNT_W'(nsr_pkg::G_W - 1);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[nsr_pkg::G_W-2:0], q_bit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/newton_square_root_top.sv -----
// Newton square root of a signed Q16.16 item: one result item per input item.
// Zero or negative input is answered in the cycle after it is taken; otherwise the result comes
// after n Newton steps through S_CHECK, S_EVAL and the serial divider in S_DIV, then a last check.
// Throughput: one item at a time; req_tready is low while an item is in work or its result waits.
// Reset (synchronous, active high) clears control and restores tolerance 4295, limit 64.
// Depends on nsr_pkg and nsr_div.

module newton_square_root_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input stream; tdata: value[31:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [nsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // Result stream; tdata: root[23:0], status[25:24], zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [nsr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Configuration writes
   input  logic                                 csr_we,
   input  logic [nsr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nsr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_DIV   = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [nsr_pkg::TOL_W-1:0]       tol_ff;
   logic [nsr_pkg::LIMIT_W-1:0]     limit_ff;
   logic [nsr_pkg::G_W-1:0]         target_ff;
   logic [nsr_pkg::G_W-1:0]         g_ff;
   logic [nsr_pkg::LIMIT_W-1:0]     steps_ff;
   logic [nsr_pkg::SQ_W-1:0]        sq_ff;
   logic                            big_ff;
   logic                            out_valid_ff;
   logic [nsr_pkg::ROOT_W-1:0]      out_root_ff;
   logic [nsr_pkg::STATUS_W-1:0]    out_status_ff;

   logic                            slot_free;
   logic                            accept;
   logic [nsr_pkg::VALUE_W-1:0]     raw;
   logic [nsr_pkg::G_W-1:0]         g_init;
   logic [nsr_pkg::SQ_W-1:0]        target_ext;
   logic [nsr_pkg::SQ_W-1:0]        err;
   logic                            close;
   logic                            out_of_steps;
   logic                            finish;
   logic                            div_start;
   logic                            div_done;
   logic [nsr_pkg::G_W-1:0]         quotient;
   logic [nsr_pkg::G_W:0]           g_sum;
   logic [nsr_pkg::G_W-1:0]         g_next;
   logic [nsr_pkg::ROOT_W-1:0]      root_sat;

   nsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (target_ff),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Handshake
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = !reset && (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign raw        = nsr_pkg::VALUE_W'(req_tdata);

   // First guess: half the operand, at least one LSB
   always_comb begin
      g_init = nsr_pkg::G_W'(raw[nsr_pkg::VALUE_W-2:1]);
      if (g_init == '0) begin
         g_init = nsr_pkg::G_W'(1);
      end
   end

   // Convergence test on the registered square
   always_comb begin
      target_ext   = nsr_pkg::SQ_W'(target_ff);
      err          = (sq_ff >= target_ext) ? (sq_ff - target_ext) : (target_ext - sq_ff);
      close        = !big_ff && (err <= nsr_pkg::SQ_W'(tol_ff));
      out_of_steps = (steps_ff >= limit_ff);
      finish       = (state_ff == S_EVAL) && (close || out_of_steps);
      div_start    = (state_ff == S_EVAL) && !close && !out_of_steps;
   end

   // Newton update: (g + q) / 2, floored to one
   always_comb begin
      g_sum  = {1'b0, g_ff} + {1'b0, quotient};
      g_next = g_sum[nsr_pkg::G_W:1];
      if (g_next == '0) begin
         g_next = nsr_pkg::G_W'(1);
      end
   end

   assign root_sat = (g_ff > nsr_pkg::G_W'(nsr_pkg::ROOT_MAX)) ?
                     nsr_pkg::ROOT_MAX : g_ff[nsr_pkg::ROOT_W-1:0];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !raw[nsr_pkg::VALUE_W-1] && raw != '0) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = S_EVAL;
         S_EVAL: begin
            if (div_start) begin
               state_in = S_DIV;
            end else if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_CHECK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= nsr_pkg::TOL_RESET;
         limit_ff <= nsr_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            nsr_pkg::CSR_TOLERANCE:  tol_ff   <= csr_wdata[nsr_pkg::TOL_W-1:0];
            nsr_pkg::CSR_ITER_LIMIT: limit_ff <= csr_wdata[nsr_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= {raw[nsr_pkg::VALUE_W-2:0], {nsr_pkg::FRACTION_BITS{1'b0}}};
         g_ff      <= g_init;
         steps_ff  <= '0;
      end else if (state_ff == S_DIV && div_done) begin
         g_ff      <= g_next;
         steps_ff  <= steps_ff + 1'b1;
      end
      // Square of the low word; a guess beyond it never converges
      if (state_ff == S_CHECK) begin
         sq_ff  <= g_ff[nsr_pkg::MUL_W-1:0] * g_ff[nsr_pkg::MUL_W-1:0];
         big_ff <= |g_ff[nsr_pkg::G_W-1:nsr_pkg::MUL_W];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && (raw[nsr_pkg::VALUE_W-1] || raw == '0)) begin
         out_valid_ff <= 1'b1;
      end else if (finish && slot_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_root_ff   <= '0;
         out_status_ff <= raw[nsr_pkg::VALUE_W-1] ? nsr_pkg::ST_NEG : nsr_pkg::ST_OK;
      end else if (finish && slot_free) begin
         out_root_ff   <= root_sat;
         out_status_ff <= close ? nsr_pkg::ST_OK : nsr_pkg::ST_LIMIT;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = nsr_pkg::RSP_DATA_W'({out_status_ff, out_root_ff});

endmodule

// ----- hw/rtl/nsr_checker.sv -----
// nsr_checker: port-level assertions for newton_square_root_top, bound to the top level.
// Depends on nsr_pkg.

module nsr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic signed [nsr_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [nsr_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   logic [nsr_pkg::STATUS_W-1:0] status;
   logic [nsr_pkg::ROOT_W-1:0]   root;
   logic                         req_acc;

   assign root    = rsp_tdata[nsr_pkg::ROOT_W-1:0];
   assign status  = rsp_tdata[nsr_pkg::RSP_FIELDS_W-1:nsr_pkg::ROOT_W];
   assign req_acc = req_tvalid && req_tready;

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Negative input gives status NEG on the next cycle
   a_neg_fast: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tdata[nsr_pkg::VALUE_W-1] |=> rsp_tvalid && status == nsr_pkg::ST_NEG)
      else $error("negative input not answered at once");

   // Zero input gives a zero item on the next cycle
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tdata == '0 |=> rsp_tvalid && rsp_tdata == '0)
      else $error("zero input not answered at once");

   // Negative status always carries a zero root
   a_neg_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == nsr_pkg::ST_NEG |-> root == '0)
      else $error("negative status with nonzero root");

   // Status code is one of the three defined ones
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status == nsr_pkg::ST_OK || status == nsr_pkg::ST_LIMIT ||
                     status == nsr_pkg::ST_NEG)
      else $error("undefined status code");

endmodule

bind newton_square_root_top nsr_checker u_nsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
